FILE: rtl/drcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcd_pkg
// Shared widths and latencies for the drift circle distance pipeline.
// ----------------------------------------------------------------------------
package drcd_pkg;

  localparam int COORD_BITS = 24;
  localparam int DRIFT_BITS = 12;
  localparam int DIST_BITS  = 26;

  // abs of a coordinate difference, its square sum and its root
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int RAD_BITS  = 2 * DIFF_BITS;
  localparam int ROOT_BITS = DIFF_BITS;

  // width for the radius compare and the final difference
  localparam int CMP_BITS = ((ROOT_BITS > DRIFT_BITS) ? ROOT_BITS : DRIFT_BITS) + 1;

  localparam int FRONT_LAT = 3;
  localparam int SQRT_LAT  = ROOT_BITS;
  localparam int BACK_LAT  = 2;
  localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + BACK_LAT;

  // stream packing
  localparam int CX_LSB   = 0;
  localparam int CY_LSB   = CX_LSB + COORD_BITS;
  localparam int WX_LSB   = CY_LSB + COORD_BITS;
  localparam int WY_LSB   = WX_LSB + COORD_BITS;
  localparam int OWX_LSB  = WY_LSB + COORD_BITS;
  localparam int OWY_LSB  = OWX_LSB + COORD_BITS;
  localparam int RW_LSB   = OWY_LSB + COORD_BITS;
  localparam int IN_FIELD_BITS = RW_LSB + DRIFT_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((DIST_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/drcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcd_front
// Wire select, absolute differences, squares and square sums (three stages).
// ----------------------------------------------------------------------------
module drcd_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] center_y,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] wire_x,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] wire_y,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] orig_wire_x,
  input  logic signed [drcd_pkg::COORD_BITS-1:0] orig_wire_y,
  input  logic                                 use_original,
  input  logic        [drcd_pkg::DRIFT_BITS-1:0] drift_radius,
  output logic        [drcd_pkg::RAD_BITS-1:0]   rad_c,
  output logic        [drcd_pkg::RAD_BITS-1:0]   rad_d,
  output logic        [drcd_pkg::DRIFT_BITS-1:0] rw
);

  logic signed [drcd_pkg::DIFF_BITS-1:0] cx_e, cy_e, wx_e, wy_e, dx_s, dy_s;
  logic        [drcd_pkg::DIFF_BITS-1:0] ax_c, ay_c, dx_c, dy_c;

  logic [drcd_pkg::DIFF_BITS-1:0]  ax, ay, dx, dy;
  logic [drcd_pkg::DRIFT_BITS-1:0] rw1, rw2;
  logic [drcd_pkg::RAD_BITS-1:0]   sq_ax, sq_ay, sq_dx, sq_dy;

  always_comb begin
    cx_e = drcd_pkg::DIFF_BITS'(center_x);
    cy_e = drcd_pkg::DIFF_BITS'(center_y);
    wx_e = use_original ? drcd_pkg::DIFF_BITS'(orig_wire_x) : drcd_pkg::DIFF_BITS'(wire_x);
    wy_e = use_original ? drcd_pkg::DIFF_BITS'(orig_wire_y) : drcd_pkg::DIFF_BITS'(wire_y);
    dx_s = cx_e - wx_e;
    dy_s = cy_e - wy_e;
    ax_c = cx_e[drcd_pkg::DIFF_BITS-1] ? -cx_e : cx_e;
    ay_c = cy_e[drcd_pkg::DIFF_BITS-1] ? -cy_e : cy_e;
    dx_c = dx_s[drcd_pkg::DIFF_BITS-1] ? -dx_s : dx_s;
    dy_c = dy_s[drcd_pkg::DIFF_BITS-1] ? -dy_s : dy_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax    <= ax_c;
      ay    <= ay_c;
      dx    <= dx_c;
      dy    <= dy_c;
      rw1   <= drift_radius;
      sq_ax <= ax * ax;
      sq_ay <= ay * ay;
      sq_dx <= dx * dx;
      sq_dy <= dy * dy;
      rw2   <= rw1;
      rad_c <= sq_ax + sq_ay;
      rad_d <= sq_dx + sq_dy;
      rw    <= rw2;
    end
  end

endmodule

FILE: rtl/drcd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcd_isqrt
// Floored integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module drcd_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [drcd_pkg::RAD_BITS-1:0]    radicand,
  output logic [drcd_pkg::ROOT_BITS-1:0]   root
);

  logic [drcd_pkg::RAD_BITS-1:0]  rem_q  [drcd_pkg::ROOT_BITS];
  logic [drcd_pkg::ROOT_BITS-1:0] root_q [drcd_pkg::ROOT_BITS];

  for (genvar k = 0; k < drcd_pkg::ROOT_BITS; k++) begin : g_step
    localparam int Bit = drcd_pkg::ROOT_BITS - 1 - k;

    logic [drcd_pkg::RAD_BITS-1:0]  rem_in;
    logic [drcd_pkg::ROOT_BITS-1:0] root_in;
    logic [drcd_pkg::RAD_BITS:0]    trial;
    logic                           take;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = ((drcd_pkg::RAD_BITS + 1)'(root_in) << (Bit + 1))
            | ((drcd_pkg::RAD_BITS + 1)'(1) << (2 * Bit));
      take  = {1'b0, rem_in} >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? rem_in - drcd_pkg::RAD_BITS'(trial) : rem_in;
        root_q[k] <= take ? (root_in | (drcd_pkg::ROOT_BITS'(1) << Bit)) : root_in;
      end
    end
  end

  assign root = root_q[drcd_pkg::ROOT_BITS-1];

endmodule

FILE: rtl/drcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcd_back
// Radius sum or difference select and final absolute gap (two stages).
// ----------------------------------------------------------------------------
module drcd_back (
  input  logic                              clk,
  input  logic                              en,
  input  logic [drcd_pkg::ROOT_BITS-1:0]    rc,
  input  logic [drcd_pkg::ROOT_BITS-1:0]    d,
  input  logic [drcd_pkg::DRIFT_BITS-1:0]   rw,
  output logic [drcd_pkg::DIST_BITS-1:0]    distance
);

  logic [drcd_pkg::CMP_BITS-1:0] rc_e, rw_e, d_e, sum_c, dif_c, ref_c;
  logic [drcd_pkg::CMP_BITS-1:0] ref_q, d_q, dist_c;

  always_comb begin
    rc_e  = drcd_pkg::CMP_BITS'(rc);
    rw_e  = drcd_pkg::CMP_BITS'(rw);
    d_e   = drcd_pkg::CMP_BITS'(d);
    sum_c = rc_e + rw_e;
    dif_c = (rc_e >= rw_e) ? rc_e - rw_e : rw_e - rc_e;
    ref_c = ((d_e > rc_e) && (d_e > rw_e)) ? sum_c : dif_c;
    dist_c = (d_q >= ref_q) ? d_q - ref_q : ref_q - d_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ref_q    <= ref_c;
      d_q      <= d_e;
      distance <= drcd_pkg::DIST_BITS'(dist_c);
    end
  end

endmodule

FILE: rtl/drift_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_circle_distance
// Distance between a track circle through the origin and a drift circle.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 25 square root stages, 2 back stages and an
//   output register; the first front stage loads at the accepting edge.
// Throughput: one transaction per cycle while the skid register is empty;
//   the two square roots are fully pipelined, one result bit per stage.
// Reset: synchronous, clears all valid bits and the output and skid valid flags.
// ----------------------------------------------------------------------------
module drift_circle_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // center_x, center_y, wire_x, wire_y, orig_wire_x, orig_wire_y, drift_radius
  input  logic [drcd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // use_original
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // distance
  output logic [drcd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  logic                              en;
  logic [drcd_pkg::PIPE_LAT-1:0]     vld;
  logic [drcd_pkg::RAD_BITS-1:0]     rad_c, rad_d;
  logic [drcd_pkg::DRIFT_BITS-1:0]   rw_f;
  logic [drcd_pkg::DRIFT_BITS-1:0]   rw_dly [drcd_pkg::SQRT_LAT];
  logic [drcd_pkg::ROOT_BITS-1:0]    rc, d;
  logic [drcd_pkg::DIST_BITS-1:0]    p_dist, out_dist, skid_dist;
  logic                              p_valid, skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign p_valid       = vld[drcd_pkg::PIPE_LAT-1];

  drcd_front u_front (
    .clk          (clk),
    .en           (en),
    .center_x     (s_axis_tdata[drcd_pkg::CX_LSB +: drcd_pkg::COORD_BITS]),
    .center_y     (s_axis_tdata[drcd_pkg::CY_LSB +: drcd_pkg::COORD_BITS]),
    .wire_x       (s_axis_tdata[drcd_pkg::WX_LSB +: drcd_pkg::COORD_BITS]),
    .wire_y       (s_axis_tdata[drcd_pkg::WY_LSB +: drcd_pkg::COORD_BITS]),
    .orig_wire_x  (s_axis_tdata[drcd_pkg::OWX_LSB +: drcd_pkg::COORD_BITS]),
    .orig_wire_y  (s_axis_tdata[drcd_pkg::OWY_LSB +: drcd_pkg::COORD_BITS]),
    .use_original (s_axis_tuser),
    .drift_radius (s_axis_tdata[drcd_pkg::RW_LSB +: drcd_pkg::DRIFT_BITS]),
    .rad_c        (rad_c),
    .rad_d        (rad_d),
    .rw           (rw_f)
  );

  drcd_isqrt u_sqrt_c (
    .clk      (clk),
    .en       (en),
    .radicand (rad_c),
    .root     (rc)
  );

  drcd_isqrt u_sqrt_d (
    .clk      (clk),
    .en       (en),
    .radicand (rad_d),
    .root     (d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rw_dly[0] <= rw_f;
      for (int i = 1; i < drcd_pkg::SQRT_LAT; i++) begin
        rw_dly[i] <= rw_dly[i-1];
      end
    end
  end

  drcd_back u_back (
    .clk      (clk),
    .en       (en),
    .rc       (rc),
    .d        (d),
    .rw       (rw_dly[drcd_pkg::SQRT_LAT-1]),
    .distance (p_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[drcd_pkg::PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= skid_valid || p_valid;
      skid_valid    <= 1'b0;
    end else if (en && p_valid) begin
      skid_valid    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      out_dist <= skid_valid ? skid_dist : p_dist;
    end else if (en) begin
      skid_dist <= p_dist;
    end
  end

  assign m_axis_tdata = drcd_pkg::OUT_DATA_BITS'(out_dist);

endmodule

FILE: rtl/drcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcd_checker
// Port-level checks for the drift circle distance block.
// ----------------------------------------------------------------------------
module drcd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [drcd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("output valid or input stall after reset");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_take_frees_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("input still stalled after output transaction");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

endmodule

bind drift_circle_distance drcd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/drift_circle_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_circle_distance_tb
// Streams track/hit pairs into the drift circle distance pipeline and
// checks each distance against a bit-exact integer predictor: directed
// corner pairs first, then random pairs sized so that both the sum and the
// difference branches occur, with random stalls on both streams, a long
// output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module drift_circle_distance_tb;

  typedef struct {
    logic signed [drcd_pkg::COORD_BITS-1:0] center_x;
    logic signed [drcd_pkg::COORD_BITS-1:0] center_y;
    logic signed [drcd_pkg::COORD_BITS-1:0] wire_x;
    logic signed [drcd_pkg::COORD_BITS-1:0] wire_y;
    logic signed [drcd_pkg::COORD_BITS-1:0] orig_wire_x;
    logic signed [drcd_pkg::COORD_BITS-1:0] orig_wire_y;
    logic                                   use_original;
    logic [drcd_pkg::DRIFT_BITS-1:0]        drift_radius;
  } track_hit_t;

  localparam int PAIR_COUNT   = 450;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_FIRST   = 200;
  localparam int CALM_LAST    = 280;
  localparam int DRAIN_AT     = 350;
  localparam int IDLE_PERCENT = 11;

  class distance_scoreboard;
    logic [drcd_pkg::DIST_BITS-1:0] expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint floor_root(longint n);
      longint r;
      longint trial;
      r = 0;
      for (int b = drcd_pkg::ROOT_BITS; b >= 0; b--) begin
        trial = r | (longint'(1) << b);
        if (trial * trial <= n) r = trial;
      end
      return r;
    endfunction

    static function logic [drcd_pkg::DIST_BITS-1:0] track_drift_distance(track_hit_t p);
      longint cx, cy, wx, wy, dx, dy, rc, d, rw, big, gap;
      cx = longint'(p.center_x);
      cy = longint'(p.center_y);
      wx = p.use_original ? longint'(p.orig_wire_x) : longint'(p.wire_x);
      wy = p.use_original ? longint'(p.orig_wire_y) : longint'(p.wire_y);
      rw = longint'(p.drift_radius);
      dx = cx - wx;
      dy = cy - wy;
      rc = floor_root(cx * cx + cy * cy);
      d  = floor_root(dx * dx + dy * dy);
      big = (rw > rc) ? rw : rc;
      if (d > big) begin
        gap = d - (rc + rw);
      end else begin
        gap = d - ((rc >= rw) ? rc - rw : rw - rc);
      end
      if (gap < 0) gap = -gap;
      return gap[drcd_pkg::DIST_BITS-1:0];
    endfunction

    function void note_pair(track_hit_t p);
      expected_q = {expected_q, track_drift_distance(p)};
    endfunction

    function void check_result(logic [drcd_pkg::DIST_BITS-1:0] got);
      logic [drcd_pkg::DIST_BITS-1:0] want;
      if (expected_q.size() == 0) begin
        $error("distance: unexpected result %0d", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("distance mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [drcd_pkg::IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                               s_axis_tuser = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [drcd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

  distance_scoreboard sb = new();
  int pairs_accepted = 0;

  drift_circle_distance dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [drcd_pkg::IN_DATA_BITS-1:0] pack_pair(track_hit_t p);
    logic [drcd_pkg::IN_DATA_BITS-1:0] v;
    v = '0;
    v[drcd_pkg::CX_LSB  +: drcd_pkg::COORD_BITS] = p.center_x;
    v[drcd_pkg::CY_LSB  +: drcd_pkg::COORD_BITS] = p.center_y;
    v[drcd_pkg::WX_LSB  +: drcd_pkg::COORD_BITS] = p.wire_x;
    v[drcd_pkg::WY_LSB  +: drcd_pkg::COORD_BITS] = p.wire_y;
    v[drcd_pkg::OWX_LSB +: drcd_pkg::COORD_BITS] = p.orig_wire_x;
    v[drcd_pkg::OWY_LSB +: drcd_pkg::COORD_BITS] = p.orig_wire_y;
    v[drcd_pkg::RW_LSB  +: drcd_pkg::DRIFT_BITS] = p.drift_radius;
    return v;
  endfunction

  function automatic track_hit_t make_pair(int cx, int cy, int wx, int wy, int owx,
                                           int owy, int use_orig, int rw);
    track_hit_t p;
    p.center_x     = cx[drcd_pkg::COORD_BITS-1:0];
    p.center_y     = cy[drcd_pkg::COORD_BITS-1:0];
    p.wire_x       = wx[drcd_pkg::COORD_BITS-1:0];
    p.wire_y       = wy[drcd_pkg::COORD_BITS-1:0];
    p.orig_wire_x  = owx[drcd_pkg::COORD_BITS-1:0];
    p.orig_wire_y  = owy[drcd_pkg::COORD_BITS-1:0];
    p.use_original = use_orig[0];
    p.drift_radius = rw[drcd_pkg::DRIFT_BITS-1:0];
    return p;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic track_hit_t random_pair();
    track_hit_t p;
    int span;
    int mode;
    int cx;
    int cy;
    int wx;
    int wy;
    int mag;
    mode = $urandom_range(9);
    p.center_x     = drcd_pkg::COORD_BITS'($urandom());
    p.center_y     = drcd_pkg::COORD_BITS'($urandom());
    p.wire_x       = drcd_pkg::COORD_BITS'($urandom());
    p.wire_y       = drcd_pkg::COORD_BITS'($urandom());
    p.orig_wire_x  = drcd_pkg::COORD_BITS'($urandom());
    p.orig_wire_y  = drcd_pkg::COORD_BITS'($urandom());
    p.use_original = 1'($urandom_range(1));
    p.drift_radius = drcd_pkg::DRIFT_BITS'($urandom());
    if (mode >= 2 && mode <= 7) begin
      // keep radii and distance comparable so both branches are hit
      span = (mode <= 5) ? 4096 : 65536;
      cx = spread(span);
      cy = spread(span);
      p.center_x = cx[drcd_pkg::COORD_BITS-1:0];
      p.center_y = cy[drcd_pkg::COORD_BITS-1:0];
      wx = spread(span);
      wy = spread(span);
      if (p.use_original) begin
        p.orig_wire_x = wx[drcd_pkg::COORD_BITS-1:0];
        p.orig_wire_y = wy[drcd_pkg::COORD_BITS-1:0];
      end else begin
        p.wire_x = wx[drcd_pkg::COORD_BITS-1:0];
        p.wire_y = wy[drcd_pkg::COORD_BITS-1:0];
      end
    end else if (mode >= 8) begin
      // wire at the origin: d equals the track radius
      cx = spread(4000);
      p.center_x = cx[drcd_pkg::COORD_BITS-1:0];
      p.center_y = '0;
      if (p.use_original) begin
        p.orig_wire_x = '0;
        p.orig_wire_y = '0;
      end else begin
        p.wire_x = '0;
        p.wire_y = '0;
      end
      mag = (cx < 0) ? -cx : cx;
      if (mode == 9) p.drift_radius = mag[drcd_pkg::DRIFT_BITS-1:0];
    end
    return p;
  endfunction

  task automatic send_pair(track_hit_t p, bit allow_gap);
    if (allow_gap) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_pair(p);
    s_axis_tuser  <= p.use_original;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pair(p);
    pairs_accepted++;
  endtask

  // output side: result checks, random stalls, one long hold-off, one calm stretch
  int  stall_left = 0;
  bit  hold_done  = 1'b0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[drcd_pkg::DIST_BITS-1:0]);
    end
    if (!hold_done && pairs_accepted >= HOLD_AT) begin
      hold_done  = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (pairs_accepted >= CALM_FIRST && pairs_accepted < CALM_LAST) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    track_hit_t directed_q[$];
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_q = {directed_q, make_pair(0, 0, 0, 0, 0, 0, 0, 0)};
    directed_q = {directed_q, make_pair(0, 0, 0, 0, 0, 0, 1, 4095)};
    directed_q = {directed_q,
                  make_pair(8388607, 8388607, -8388608, -8388608, 0, 0, 0, 4095)};
    directed_q = {directed_q,
                  make_pair(-8388608, -8388608, 8388607, 8388607, 5, 5, 0, 0)};
    directed_q = {directed_q,
                  make_pair(-8388608, -8388608, 0, 0, 8388607, 8388607, 1, 4095)};
    directed_q = {directed_q,
                  make_pair(8388607, -8388608, 123, -77, -8388608, 8388607, 1, 0)};
    directed_q = {directed_q,
                  make_pair(-8388608, 8388607, 8388607, -8388608, -1, -1, 0, 2048)};
    directed_q = {directed_q, make_pair(256, 0, 0, 0, 999, 999, 0, 0)};
    directed_q = {directed_q, make_pair(0, 0, 999, 999, 100, 0, 1, 100)};
    directed_q = {directed_q, make_pair(-5000, 0, -5000, 5000, 1, 1, 0, 4095)};
    directed_q = {directed_q, make_pair(1000, 0, 3000, 0, -3000, 0, 0, 50)};
    directed_q = {directed_q, make_pair(1000, 0, 3000, 0, -3000, 0, 1, 50)};
    directed_q = {directed_q, make_pair(3000, 4000, 3000, 4000, 0, 0, 0, 4095)};
    directed_q = {directed_q, make_pair(3000, 4000, 0, 0, 3000, 4000, 1, 1)};
    directed_q = {directed_q, make_pair(-1, -1, 1, 1, -1, -1, 1, 4095)};
    directed_q = {directed_q, make_pair(0, 2047, 0, -2048, 0, 0, 0, 2047)};
    directed_q = {directed_q, make_pair(4095, 0, 0, 0, 8191, 0, 1, 4095)};
    directed_q = {directed_q, make_pair(-2, 0, 4, 0, 0, 0, 0, 1)};
    foreach (directed_q[i]) send_pair(directed_q[i], 1'b1);

    n = directed_q.size();
    for (int i = n; i < PAIR_COUNT; i++) begin
      if (i == DRAIN_AT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_pair(random_pair(), !(i >= CALM_FIRST && i < CALM_LAST));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (drcd_pkg::PIPE_LAT + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
